// ===== hw/rtl/srqt_pkg.sv =====
// Shared types and constants for the spatial radius query table.
package srqt_pkg;

    localparam int MaxEntriesDef = 32;
    localparam int CoordBitsDef  = 20;
    localparam int ResultLimit   = 32;
    localparam int EmitCntW      = 6;
    localparam int IdW           = 32;
    localparam int MaskW         = 8;
    localparam int DistW         = 44;
    localparam int CountW        = 6;
    localparam int StatusW       = 2;
    localparam int KindW         = 3;

    localparam logic [KindW-1:0] KIND_UPSERT  = 3'd0;
    localparam logic [KindW-1:0] KIND_REMOVE  = 3'd1;
    localparam logic [KindW-1:0] KIND_CLEAR   = 3'd2;
    localparam logic [KindW-1:0] KIND_RADIUS  = 3'd3;
    localparam logic [KindW-1:0] KIND_NEAREST = 3'd4;

    localparam logic [StatusW-1:0] ST_OK       = 2'd0;
    localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [StatusW-1:0] ST_IDZERO   = 2'd2;
    localparam logic [StatusW-1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RSQ,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SQX,
        S_SQY,
        S_SUM,
        S_CMP,
        S_PASS_END,
        S_CHECK,
        S_EMIT
    } state_t;

endpackage

// ===== hw/rtl/srqt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/spatial_radius_query_table_top.sv =====
// Top level of the spatial radius query table: sequencer, shared squarer and point store.
//
// Input items arrive on the s_ group (tuser = kind, tdata = id, position, radius, masks).
// s_tready is high only while the block is idle; one operation runs at a time.
// Results leave on the m_ group through an output register; tlast marks the final
// result of an operation and tuser carries the status.
// Upserts and removes with a nonzero id, and queries with a non-negative radius, sweep
// all MAX_ENTRIES slots through one RAM read port. Each slot is read, then checked; in
// a query sweep one shared multiplier squares dx then dy of a matching slot before the
// sum and the key compare.
// Queries sort by repeated minimum-selection sweeps: k hits take k+1 sweeps, or k when
// the ResultLimit cap is reached (nearest: one sweep), after the radius is squared.
// Clear and unknown kinds skip the sweep and go straight to the result.
// When the receiver stalls, the sequencer holds the next result until the output
// register is free; no result is lost.
// Reset empties the table (all slot valid flags cleared, count zero) and needs
// no clearing pass; slot contents are never used before they are written.
module spatial_radius_query_table_top
    import srqt_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDef,
    parameter int COORD_BITS  = CoordBitsDef,
    parameter int IN_DW  = ((IdW + 3 * COORD_BITS + 1 + 2 * MaskW + 7) / 8) * 8,
    parameter int OUT_DW = ((IdW + DistW + CountW + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // item_id, pos_x, pos_y, radius, team_bits, category_bits (from bit 0)
    input  logic [IN_DW-1:0]            s_tdata,
    // kind
    input  logic [srqt_pkg::KindW-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // hit_id, hit_dist_sq, entry_count (from bit 0)
    output logic [OUT_DW-1:0]           m_tdata,
    // status
    output logic [srqt_pkg::StatusW-1:0] m_tuser,
    output logic                        m_tlast
);

    localparam int C    = COORD_BITS;
    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW   = $clog2(MAX_ENTRIES + 1);
    localparam int MW   = C + 1;
    localparam int PW   = 2 * MW;
    localparam int DW   = PW + 1;
    localparam int RW   = IdW + 2 * C + 2 * MaskW;
    localparam int X_LO = IdW;
    localparam int Y_LO = IdW + C;
    localparam int R_LO = IdW + 2 * C;
    localparam int T_LO = IdW + 3 * C + 1;
    localparam int K_LO = T_LO + MaskW;

    state_t state_reg, state_next;

    logic [KindW-1:0]   kind_reg;
    logic [IdW-1:0]     id_reg;
    logic signed [C-1:0] px_reg, py_reg;
    logic signed [C:0]  rad_reg;
    logic [MaskW-1:0]   tm_reg, cm_reg;

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [NW-1:0]      count_reg;
    logic [IW-1:0]      idx_reg;
    logic               found_reg, free_seen_reg;
    logic [IW-1:0]      found_idx_reg, free_idx_reg;

    logic [PW-1:0]      rsq_reg;
    logic [MW-1:0]      dx_reg, dy_reg;
    logic [PW-1:0]      sqx_reg, sqy_reg;
    logic [DW-1:0]      d2_reg;
    logic [IdW-1:0]     cand_id_reg;

    logic               best_valid_reg, pend_valid_reg;
    logic [DW-1:0]      best_d2_reg, pend_d2_reg;
    logic [IdW-1:0]     best_id_reg, pend_id_reg;
    logic [EmitCntW-1:0] emit_cnt_reg;

    logic [StatusW-1:0] res_status_reg;
    logic [IdW-1:0]     res_id_reg;
    logic [DW-1:0]      res_d2_reg;
    logic               res_last_reg, res_more_reg;

    logic               out_valid_reg;
    logic [StatusW-1:0] out_status_reg;
    logic [IdW-1:0]     out_id_reg;
    logic [DW-1:0]      out_d2_reg;
    logic               out_last_reg;
    logic [NW-1:0]      out_count_reg;

    // RAM
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [RW-1:0]      ram_wdata, ram_rdata;
    logic [IdW-1:0]     slot_id;
    logic signed [C-1:0] slot_x, slot_y;
    logic [MaskW-1:0]   slot_team, slot_cat;

    logic [MW-1:0]      mul_a;
    logic [PW-1:0]      mul_p;
    logic               out_free, in_xfer, is_query, last_idx, slot_hit;
    logic               above_pend, below_best, in_radius;
    logic signed [C:0]  dxs, dys;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign is_query = (kind_reg == KIND_RADIUS) || (kind_reg == KIND_NEAREST);
    assign last_idx = (idx_reg == IW'(MAX_ENTRIES - 1));

    assign slot_id   = ram_rdata[IdW-1:0];
    assign slot_x    = ram_rdata[IdW +: C];
    assign slot_y    = ram_rdata[IdW + C +: C];
    assign slot_team = ram_rdata[IdW + 2 * C +: MaskW];
    assign slot_cat  = ram_rdata[IdW + 2 * C + MaskW +: MaskW];

    assign ram_waddr = found_reg ? found_idx_reg : free_idx_reg;
    assign ram_wdata = {cm_reg, tm_reg, py_reg, px_reg, id_reg};

    srqt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    // shared squarer
    assign mul_p = mul_a * mul_a;

    assign dxs = (C + 1)'(slot_x) - (C + 1)'(px_reg);
    assign dys = (C + 1)'(slot_y) - (C + 1)'(py_reg);

    assign slot_hit = valid_reg[idx_reg]
                   && !(kind_reg == KIND_NEAREST && id_reg != '0 && slot_id == id_reg)
                   && (tm_reg == '0 || (slot_team & tm_reg) != '0)
                   && (cm_reg == '0 || (slot_cat & cm_reg) != '0);

    assign in_radius  = d2_reg <= DW'(rsq_reg);
    assign above_pend = !pend_valid_reg || (d2_reg > pend_d2_reg)
                     || (d2_reg == pend_d2_reg && cand_id_reg > pend_id_reg);
    assign below_best = !best_valid_reg || (d2_reg < best_d2_reg)
                     || (d2_reg == best_d2_reg && cand_id_reg < best_id_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (s_tuser)
                        KIND_UPSERT, KIND_REMOVE:
                            state_next = (s_tdata[IdW-1:0] == '0) ? S_EMIT : S_SCAN_RD;
                        KIND_RADIUS, KIND_NEAREST:
                            state_next = S_RSQ;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end
            S_RSQ:      state_next = rad_reg[C] ? S_EMIT : S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (is_query && slot_hit)
                    state_next = S_SQX;
                else if (last_idx)
                    state_next = S_PASS_END;
                else
                    state_next = S_SCAN_RD;
            end
            S_SQX:      state_next = S_SQY;
            S_SQY:      state_next = S_SUM;
            S_SUM:      state_next = S_CMP;
            S_CMP:      state_next = last_idx ? S_PASS_END : S_SCAN_RD;
            S_PASS_END:
            begin
                if (is_query && best_valid_reg && !pend_valid_reg)
                    state_next = S_CHECK;
                else
                    state_next = S_EMIT;
            end
            S_CHECK:
            begin
                if (kind_reg == KIND_NEAREST || emit_cnt_reg == EmitCntW'(ResultLimit - 1))
                    state_next = S_EMIT;
                else
                    state_next = S_SCAN_RD;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = res_more_reg ? S_CHECK : S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // decoded outputs
    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        ram_we   = (state_reg == S_PASS_END) && (kind_reg == KIND_UPSERT)
                && (found_reg || free_seen_reg);
        case (state_reg)
            S_RSQ:   mul_a = MW'(rad_reg);
            S_SQX:   mul_a = dx_reg;
            default: mul_a = dy_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_IDLE && in_xfer && s_tuser == KIND_CLEAR)
            begin
                valid_reg <= '0;
                count_reg <= '0;
            end
            if (state_reg == S_PASS_END)
            begin
                if (kind_reg == KIND_UPSERT && !found_reg && free_seen_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
                if (kind_reg == KIND_REMOVE && found_reg)
                begin
                    valid_reg[found_idx_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                kind_reg       <= s_tuser;
                id_reg         <= s_tdata[IdW-1:0];
                px_reg         <= s_tdata[X_LO +: C];
                py_reg         <= s_tdata[Y_LO +: C];
                rad_reg        <= s_tdata[R_LO +: C + 1];
                tm_reg         <= s_tdata[T_LO +: MaskW];
                cm_reg         <= s_tdata[K_LO +: MaskW];
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_seen_reg  <= 1'b0;
                best_valid_reg <= 1'b0;
                pend_valid_reg <= 1'b0;
                emit_cnt_reg   <= '0;
                res_d2_reg     <= '0;
                res_last_reg   <= 1'b1;
                res_more_reg   <= 1'b0;
                res_id_reg     <= (s_tuser == KIND_REMOVE) ? s_tdata[IdW-1:0] : '0;
                case (s_tuser)
                    KIND_UPSERT:
                        res_status_reg <= ST_IDZERO;
                    KIND_CLEAR:
                        res_status_reg <= ST_OK;
                    default:
                        res_status_reg <= ST_NOTFOUND;
                endcase
            end
            S_RSQ:
                rsq_reg <= mul_p;
            S_SCAN_CHK:
            begin
                cand_id_reg <= slot_id;
                dx_reg <= dxs[C] ? MW'(-dxs) : MW'(dxs);
                dy_reg <= dys[C] ? MW'(-dys) : MW'(dys);
                if (!is_query)
                begin
                    if (valid_reg[idx_reg] && slot_id == id_reg)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= idx_reg;
                    end
                    if (!valid_reg[idx_reg] && !free_seen_reg)
                    begin
                        free_seen_reg <= 1'b1;
                        free_idx_reg  <= idx_reg;
                    end
                end
                if (!(is_query && slot_hit) && !last_idx)
                    idx_reg <= idx_reg + 1'b1;
            end
            S_SQX:
                sqx_reg <= mul_p;
            S_SQY:
                sqy_reg <= mul_p;
            S_SUM:
                d2_reg <= DW'(sqx_reg) + DW'(sqy_reg);
            S_CMP:
            begin
                if (in_radius && above_pend && below_best)
                begin
                    best_valid_reg <= 1'b1;
                    best_d2_reg    <= d2_reg;
                    best_id_reg    <= cand_id_reg;
                end
                if (!last_idx)
                    idx_reg <= idx_reg + 1'b1;
            end
            S_PASS_END:
            begin
                if (kind_reg == KIND_UPSERT)
                begin
                    res_id_reg     <= id_reg;
                    res_status_reg <= (found_reg || free_seen_reg) ? ST_OK : ST_FULL;
                    res_d2_reg     <= '0;
                    res_last_reg   <= 1'b1;
                    res_more_reg   <= 1'b0;
                end
                else if (kind_reg == KIND_REMOVE)
                begin
                    res_id_reg     <= id_reg;
                    res_status_reg <= found_reg ? ST_OK : ST_NOTFOUND;
                    res_d2_reg     <= '0;
                    res_last_reg   <= 1'b1;
                    res_more_reg   <= 1'b0;
                end
                else if (pend_valid_reg)
                begin
                    // pending hit is final unless this sweep found a successor
                    res_status_reg <= ST_OK;
                    res_id_reg     <= pend_id_reg;
                    res_d2_reg     <= pend_d2_reg;
                    if (best_valid_reg)
                    begin
                        res_last_reg   <= 1'b0;
                        res_more_reg   <= 1'b1;
                        pend_d2_reg    <= best_d2_reg;
                        pend_id_reg    <= best_id_reg;
                        emit_cnt_reg   <= emit_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        res_last_reg   <= 1'b1;
                        res_more_reg   <= 1'b0;
                    end
                end
                else if (best_valid_reg)
                begin
                    pend_valid_reg <= 1'b1;
                    pend_d2_reg    <= best_d2_reg;
                    pend_id_reg    <= best_id_reg;
                end
                else
                begin
                    res_status_reg <= ST_NOTFOUND;
                    res_id_reg     <= '0;
                    res_d2_reg     <= '0;
                    res_last_reg   <= 1'b1;
                    res_more_reg   <= 1'b0;
                end
            end
            S_CHECK:
            begin
                // restart the sweep above the pending key, or release it as the last hit
                idx_reg        <= '0;
                best_valid_reg <= 1'b0;
                res_status_reg <= ST_OK;
                res_id_reg     <= pend_id_reg;
                res_d2_reg     <= pend_d2_reg;
                res_last_reg   <= 1'b1;
                res_more_reg   <= 1'b0;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_id_reg     <= res_id_reg;
                    out_d2_reg     <= res_d2_reg;
                    out_last_reg   <= res_last_reg;
                    out_count_reg  <= count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_DW'({CountW'(out_count_reg), DistW'(out_d2_reg), out_id_reg});

endmodule
